[design/pfws_pkg.sv]
// Package for the pump, fan and water supervisor: event codes, register
// indexes, reset values and the structs passed between the modules.
// No dependencies.
package pfws_pkg;

	// Event kinds carried in the func field.
	typedef enum logic [2:0] {
		FUNC_TICK   = 3'd0,
		FUNC_PUMP   = 3'd1,
		FUNC_TEMP   = 3'd2,
		FUNC_WATER  = 3'd3,
		FUNC_BRIGHT = 3'd4
	} func_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_MAX_PUMP_SECONDS = 3'd0,
		CFG_FAN_ON_TEMP      = 3'd1,
		CFG_FAN_OFF_TEMP     = 3'd2,
		CFG_TEMP_DELTA       = 3'd3,
		CFG_WATER_THRESHOLD  = 3'd4,
		CFG_WATER_BAND       = 3'd5
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register reset values.
	localparam logic [15:0]        MAX_PUMP_RESET   = 16'd900;
	localparam logic signed [11:0] FAN_ON_RESET     = 12'sd512;
	localparam logic signed [11:0] FAN_OFF_RESET    = 12'sd480;
	localparam logic [11:0]        TEMP_DELTA_RESET = 12'd4;
	localparam logic [11:0]        WATER_THR_RESET  = 12'd1500;
	localparam logic [11:0]        WATER_HYS_RESET  = 12'd100;

	// Remaining run time counter and its ceiling.
	localparam int          REM_W      = 26;
	localparam logic [25:0] REMAIN_MAX = 26'h3FF_FFFF;

	// A sample is accepted strictly between -100 and 125 degC (1/16 degC units).
	localparam logic signed [11:0] TEMP_LOW  = -12'sd1600;
	localparam logic signed [11:0] TEMP_HIGH = 12'sd2000;

	// Highest accepted brightness percentage.
	localparam logic [7:0] PCT_MAX = 8'd100;

	typedef struct packed {
		logic [15:0]        max_pump_seconds;
		logic signed [11:0] fan_on_temp;
		logic signed [11:0] fan_off_temp;
		logic [11:0]        temp_delta;
		logic [11:0]        water_threshold;
		logic [11:0]        water_band;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         func;
		logic [15:0]        duration_seconds;
		logic signed [11:0] temperature;
		logic [11:0]        water_raw;
		logic [7:0]         brightness;
	} item_t;

	typedef struct packed {
		logic               pump_on;
		logic               fan_on;
		logic               water_empty;
		logic [7:0]         pwm_level;
		logic               temp_known;
		logic signed [11:0] temp_stored;
		logic               changed;
		logic               rejected;
	} res_t;

endpackage

[design/pfws_cfg_regs.sv]
// Configuration register bank of the supervisor.
// Depends on pfws_pkg for the register indexes, reset values and cfg_t.
module pfws_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pfws_pkg::cfg_t                      cfg
);

	pfws_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pump_seconds <= pfws_pkg::MAX_PUMP_RESET;
			cfg_q.fan_on_temp      <= pfws_pkg::FAN_ON_RESET;
			cfg_q.fan_off_temp     <= pfws_pkg::FAN_OFF_RESET;
			cfg_q.temp_delta       <= pfws_pkg::TEMP_DELTA_RESET;
			cfg_q.water_threshold  <= pfws_pkg::WATER_THR_RESET;
			cfg_q.water_band       <= pfws_pkg::WATER_HYS_RESET;
		end else if (cfg_we) begin
			case (pfws_pkg::cfg_idx_t'(cfg_index))
				pfws_pkg::CFG_MAX_PUMP_SECONDS: cfg_q.max_pump_seconds <= cfg_data;
				pfws_pkg::CFG_FAN_ON_TEMP:      cfg_q.fan_on_temp      <= cfg_data[11:0];
				pfws_pkg::CFG_FAN_OFF_TEMP:     cfg_q.fan_off_temp     <= cfg_data[11:0];
				pfws_pkg::CFG_TEMP_DELTA:       cfg_q.temp_delta       <= cfg_data[11:0];
				pfws_pkg::CFG_WATER_THRESHOLD:  cfg_q.water_threshold  <= cfg_data[11:0];
				pfws_pkg::CFG_WATER_BAND:       cfg_q.water_band       <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/pfws_core.sv]
// Supervisor state registers and the single-pass next-state logic that
// turns one event into the new state and its result.
// Depends on pfws_pkg for the event codes, constants and structs.
module pfws_core #(
	parameter int TICKS_PER_SECOND = 1000,
	parameter int PWM_BITS         = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  pfws_pkg::item_t item,
	input  pfws_pkg::cfg_t  cfg,
	output pfws_pkg::res_t  res
);

	localparam int REM_W   = pfws_pkg::REM_W;
	localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
	localparam int PROD_W  = 16 + TPS_W;
	localparam int EXT_W   = (PROD_W > REM_W) ? PROD_W : REM_W + 1;
	localparam int PWM_MAX = (1 << PWM_BITS) - 1;
	localparam logic [EXT_W-1:0] TPS_C    = EXT_W'(TICKS_PER_SECOND);
	localparam logic [EXT_W-1:0] REM_CEIL = EXT_W'(pfws_pkg::REMAIN_MAX);

	// State.
	logic                pump_q, fan_q, tv_q, wflag_q, wseen_q;
	logic [REM_W-1:0]    rem_q;
	logic signed [11:0]  tval_q;
	logic [PWM_BITS-1:0] pwm_q;

	logic                pump_d, fan_d, tv_d, wflag_d, wseen_d, rej;
	logic [REM_W-1:0]    rem_d;
	logic signed [11:0]  tval_d;
	logic [PWM_BITS-1:0] pwm_d;

	// Brightness to duty level table, worked out at elaboration.
	logic [PWM_BITS-1:0] pwm_lut [0:100];

	for (genvar gi = 0; gi <= 100; gi++) begin : g_lut
		assign pwm_lut[gi] = PWM_BITS'((gi * PWM_MAX) / 100);
	end

	// Tick countdown.
	logic [REM_W-1:0] rem_dec;
	assign rem_dec = (rem_q != '0) ? rem_q - REM_W'(1) : rem_q;

	// Trigger: clamp the request, scale to ticks and saturate.
	logic [15:0]      dur_cl;
	logic [EXT_W-1:0] ticks_full;
	logic [REM_W-1:0] ticks;
	assign dur_cl     = (item.duration_seconds > cfg.max_pump_seconds) ?
		cfg.max_pump_seconds : item.duration_seconds;
	assign ticks_full = EXT_W'(dur_cl) * TPS_C;
	assign ticks      = (ticks_full > REM_CEIL) ? pfws_pkg::REMAIN_MAX : ticks_full[REM_W-1:0];

	// Temperature: range check, distance from the stored value, fan hysteresis.
	logic               temp_ok, temp_upd, fan_wants;
	logic signed [12:0] diff;
	logic [12:0]        diff_abs;
	assign temp_ok   = (item.temperature > pfws_pkg::TEMP_LOW) &&
		(item.temperature < pfws_pkg::TEMP_HIGH);
	assign diff      = {item.temperature[11], item.temperature} - {tval_q[11], tval_q};
	assign diff_abs  = diff[12] ? 13'(-diff) : 13'(diff);
	assign temp_upd  = !tv_q || (diff_abs >= {1'b0, cfg.temp_delta});
	assign fan_wants = fan_q ? (item.temperature >= cfg.fan_off_temp) :
		(item.temperature >= cfg.fan_on_temp);

	// Water: band edges kept in 13 bits so that nothing wraps.
	logic [12:0] band_hi, raw_plus_hys;
	assign band_hi      = {1'b0, cfg.water_threshold} + {1'b0, cfg.water_band};
	assign raw_plus_hys = {1'b0, item.water_raw} + {1'b0, cfg.water_band};

	always_comb begin
		pump_d  = pump_q;
		rem_d   = rem_q;
		fan_d   = fan_q;
		tv_d    = tv_q;
		tval_d  = tval_q;
		wflag_d = wflag_q;
		wseen_d = wseen_q;
		pwm_d   = pwm_q;
		rej     = 1'b0;
		case (pfws_pkg::func_t'(item.func))
			pfws_pkg::FUNC_TICK: begin
				if (pump_q) begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						pump_d = 1'b0;
						fan_d  = tv_q && (tval_q >= cfg.fan_off_temp);
					end
				end
			end
			pfws_pkg::FUNC_PUMP: begin
				if (item.duration_seconds == '0) begin
					rej = 1'b1;
				end else begin
					rem_d  = ticks;
					pump_d = 1'b1;
					fan_d  = 1'b1;
				end
			end
			pfws_pkg::FUNC_TEMP: begin
				if (temp_ok) begin
					if (temp_upd) begin
						tval_d = item.temperature;
						tv_d   = 1'b1;
					end
					fan_d = pump_q || fan_wants;
				end else begin
					rej = 1'b1;
				end
			end
			pfws_pkg::FUNC_WATER: begin
				if (!wseen_q) begin
					wflag_d = item.water_raw < cfg.water_threshold;
				end else if (wflag_q && ({1'b0, item.water_raw} > band_hi)) begin
					wflag_d = 1'b0;
				end else if (!wflag_q && (raw_plus_hys < {1'b0, cfg.water_threshold})) begin
					wflag_d = 1'b1;
				end
				wseen_d = 1'b1;
			end
			pfws_pkg::FUNC_BRIGHT: begin
				if (item.brightness > pfws_pkg::PCT_MAX) begin
					rej = 1'b1;
				end else begin
					pwm_d = pwm_lut[item.brightness[6:0]];
				end
			end
			default: begin
				rej = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q  <= 1'b0;
			rem_q   <= '0;
			fan_q   <= 1'b0;
			tv_q    <= 1'b0;
			tval_q  <= '0;
			wflag_q <= 1'b0;
			wseen_q <= 1'b0;
			pwm_q   <= '0;
		end else if (step) begin
			pump_q  <= pump_d;
			rem_q   <= rem_d;
			fan_q   <= fan_d;
			tv_q    <= tv_d;
			tval_q  <= tval_d;
			wflag_q <= wflag_d;
			wseen_q <= wseen_d;
			pwm_q   <= pwm_d;
		end
	end

	always_comb begin
		res.pump_on     = pump_d;
		res.fan_on      = fan_d;
		res.water_empty = wflag_d;
		res.pwm_level   = 8'(pwm_d);
		res.temp_known  = tv_d;
		res.temp_stored = tval_d;
		res.changed     = (pump_d != pump_q) || (fan_d != fan_q) || (wflag_d != wflag_q) ||
			(tv_d != tv_q) || (tval_d != tval_q) || (pwm_d != pwm_q);
		res.rejected    = rej;
	end

endmodule

[design/pump_fan_water_supervisor.sv]
// Top level of the pump, fan and water supervisor: input register, result
// register and handshakes around pfws_cfg_regs and pfws_core.
// Depends on pfws_pkg, pfws_cfg_regs and pfws_core.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------
//   input     in_valid / in_ready     func, duration_seconds, temperature,
//                                     water_raw, brightness
//   result    out_valid / out_ready   pump_on, fan_on, water_empty, pwm_level,
//                                     temp_known, temp_stored, changed, rejected
//   config    cfg_we (no wait)        cfg_index, cfg_data
//
// Every event yields exactly one result. The transaction loads the input
// register; when the result register may load, the next-state logic settles
// into the state and result registers, and the result is then offered.
// Throughput is one event per clock while the result is not stalled by out_ready.
// Reset (arst_n low) clears both valid flags and all supervisor state at once.
// A stalled result holds the result register; the input register still takes
// one further transaction, after which in_ready falls until out_ready returns.
module pump_fan_water_supervisor #(
	parameter int TICKS_PER_SECOND = 1000,
	parameter int PWM_BITS         = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Event input.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic [15:0]                     duration_seconds,
	input  logic signed [11:0]              temperature,
	input  logic [11:0]                     water_raw,
	input  logic [7:0]                      brightness,
	// Result output.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            pump_on,
	output logic                            fan_on,
	output logic                            water_empty,
	output logic [7:0]                      pwm_level,
	output logic                            temp_known,
	output logic signed [11:0]              temp_stored,
	output logic                            changed,
	output logic                            rejected,
	// Configuration writes.
	input  logic                            cfg_we,
	input  logic [pfws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfws_pkg::CFG_DATA_W-1:0] cfg_data
);

	pfws_pkg::cfg_t  cfg;
	pfws_pkg::item_t item_s1;
	pfws_pkg::res_t  res, res_s2;
	logic            valid_s1, valid_s2;
	logic            advance, step;

	// The result register may load when it is empty or being emptied; the
	// input register may load when it is empty or its contents move on this cycle.
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	pfws_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: one transaction held until the core consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func             <= func;
			item_s1.duration_seconds <= duration_seconds;
			item_s1.temperature      <= temperature;
			item_s1.water_raw        <= water_raw;
			item_s1.brightness       <= brightness;
		end
	end

	// The core updates its state on exactly the cycles that load a result.
	pfws_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.PWM_BITS         (PWM_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign pump_on     = res_s2.pump_on;
	assign fan_on      = res_s2.fan_on;
	assign water_empty = res_s2.water_empty;
	assign pwm_level   = res_s2.pwm_level;
	assign temp_known  = res_s2.temp_known;
	assign temp_stored = res_s2.temp_stored;
	assign changed     = res_s2.changed;
	assign rejected    = res_s2.rejected;

	// A rejected event never alters any reported state.
	a_reject_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rejected && changed))
		else $error("rejected event reported a change");

	// The fan is forced on for as long as the pump runs.
	a_pump_implies_fan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pump_on) |-> fan_on)
		else $error("pump running with fan off");

	// No stored temperature is reported before one is known.
	a_temp_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !temp_known) |-> (temp_stored == '0))
		else $error("stored temperature nonzero while unknown");

	// A transaction into a full input register needs the core to move on.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |-> step)
		else $error("input register overwritten");

endmodule
